### rtl/nfid_pkg.sv
`default_nettype none

package nfid_pkg;

  // map geometry: 64 used bits per memory word
  localparam int WORD_BITS = 64;
  localparam int BIT_W = 6;

  // identifier fields on the ports
  localparam int ID_IO_W = 10;

  // default identifier space
  localparam int DEF_ID_COUNT = 1024;

  // request codes
  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  // controller states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_EVAL,
    S_WRITE,
    S_RESULT
  } state_t;

  // word scan result
  typedef struct packed {
    logic             hit;
    logic [BIT_W-1:0] pos;
  } scan_t;

endpackage

`default_nettype wire

### rtl/nfid_ram.sv
`default_nettype none

module nfid_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/nfid_scan.sv
`default_nettype none

module nfid_scan
  import nfid_pkg::*;
(
  input  wire logic [WORD_BITS-1:0] map_word,
  input  wire logic [WORD_BITS-1:0] window,
  output scan_t                     result
);

  logic [WORD_BITS-1:0] clear_bits;

  assign clear_bits = ~map_word & window;

  // lowest clear bit inside the search window
  always_comb begin
    result.hit = |clear_bits;
    result.pos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (clear_bits[i]) begin
        result.pos = BIT_W'(i);
      end
    end
  end

endmodule

`default_nettype wire

### rtl/next_fit_id_bitmap_allocator_unit.sv
// Next-fit identifier allocator.
// Input channel (in_valid/in_ready): op selects allocate or free; id_in is the
// identifier to free. A free of identifier zero or of one outside the space
// is dropped. A free gives no result word; an allocate gives one result word
// on the output channel (out_valid/out_ready): id_out with granted set, or
// zero with granted clear when every identifier is in use.
// The used map lives in a memory of 64-bit words, one read-modify-write at a
// time. A free reads its word, clears the bit, writes it back and returns to
// idle. An allocate scans word by word from the hint, each word a registered
// memory read, then a scan, over at most WORDS+1 words; on a hit the word is
// written back before the result. One request is in work at a time.
// After reset a clearing pass writes every map word and sets identifier
// zero; no word is accepted meanwhile. The search hint resets to one.
// The result sits in an output register; a new request is accepted while it
// waits. An allocate that finishes while the register is still full holds
// until the receiver takes the pending word.
`default_nettype none

module next_fit_id_bitmap_allocator_unit
  import nfid_pkg::*;
#(
  parameter int ID_COUNT = DEF_ID_COUNT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               op,
  input  wire logic [ID_IO_W-1:0] id_in,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic      [ID_IO_W-1:0] id_out,
  output logic                    granted
);

  localparam int WORDS = (ID_COUNT + WORD_BITS - 1) / WORD_BITS;
  localparam int WAW = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int IDW = $clog2(ID_COUNT);
  localparam int KW = $clog2(WORDS + 1);
  localparam int TAIL = ID_COUNT - (WORDS - 1) * WORD_BITS;
  localparam logic [WORD_BITS-1:0] TAIL_MASK = {WORD_BITS{1'b1}} >> (WORD_BITS - TAIL);
  localparam logic [WAW-1:0] LAST_WORD = WAW'(WORDS - 1);
  localparam logic [KW-1:0] LAST_STEP = KW'(WORDS);

  state_t state, state_next;

  logic [WAW-1:0]       clr_cnt;
  logic [IDW-1:0]       hint;
  op_t                  op_q;
  logic [BIT_W-1:0]     bit_q;
  logic [WAW-1:0]       waddr;
  logic [KW-1:0]        step;
  logic [WORD_BITS-1:0] wdata_q;
  logic [IDW-1:0]       found_q;
  logic                 grant_q;

  logic                 in_fire;
  logic                 free_ok;
  logic                 slot_free;
  logic                 mem_we;
  logic                 mem_re;
  logic [WAW-1:0]       mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic [WORD_BITS-1:0] rdata;
  logic [WORD_BITS-1:0] head_mask;
  logic [WORD_BITS-1:0] window;
  logic [IDW:0]         hint_inc;
  scan_t                scan;

  // used map storage
  nfid_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(WORDS)
  ) u_map (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(waddr),
    .rdata(rdata)
  );

  // search window: from hint up on the first word, below hint on the wrap word, inside the space on the last word
  always_comb begin
    head_mask = {WORD_BITS{1'b1}} << hint[BIT_W-1:0];
    window = {WORD_BITS{1'b1}};
    if (step == '0) begin
      window = window & head_mask;
    end
    if (step == LAST_STEP) begin
      window = window & ~head_mask;
    end
    if (waddr == LAST_WORD) begin
      window = window & TAIL_MASK;
    end
  end

  nfid_scan u_scan (
    .map_word(rdata),
    .window  (window),
    .result  (scan)
  );

  assign in_fire = in_valid && in_ready;
  assign free_ok = (id_in != '0) && (32'(id_in) < ID_COUNT);
  assign slot_free = !out_valid || out_ready;
  assign hint_inc = {1'b0, found_q} + 1'b1;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        if (clr_cnt == LAST_WORD) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          if (op_t'(op) == OP_ALLOC || free_ok) begin
            state_next = S_READ;
          end
        end
      end
      S_READ: state_next = S_EVAL;
      S_EVAL: begin
        if (op_q == OP_FREE || scan.hit) begin
          state_next = S_WRITE;
        end else if (step == LAST_STEP) begin
          state_next = S_RESULT;
        end else begin
          state_next = S_READ;
        end
      end
      S_WRITE: begin
        state_next = (op_q == OP_ALLOC) ? S_RESULT : S_IDLE;
      end
      S_RESULT: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // memory and handshake controls
  always_comb begin
    in_ready = 1'b0;
    mem_re = 1'b0;
    mem_we = 1'b0;
    mem_waddr = waddr;
    mem_wdata = wdata_q;
    unique case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_waddr = clr_cnt;
        mem_wdata = WORD_BITS'(clr_cnt == '0);
      end
      S_IDLE:   in_ready = 1'b1;
      S_READ:   mem_re = 1'b1;
      S_EVAL:   ;
      S_WRITE:  mem_we = 1'b1;
      S_RESULT: ;
      default:  ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_cnt <= '0;
      hint <= IDW'(1);
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (state == S_WRITE && op_q == OP_ALLOC) begin
        if (32'(hint_inc) >= ID_COUNT) begin
          hint <= IDW'(1);
        end else begin
          hint <= hint_inc[IDW-1:0];
        end
      end
      if (state == S_RESULT && slot_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // request and scan datapath
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_q <= op_t'(op);
      bit_q <= id_in[BIT_W-1:0];
      step <= '0;
      if (op_t'(op) == OP_FREE) begin
        waddr <= WAW'(id_in >> BIT_W);
      end else begin
        waddr <= WAW'(hint >> BIT_W);
      end
    end
    if (state == S_EVAL) begin
      if (op_q == OP_FREE) begin
        wdata_q <= rdata & ~(WORD_BITS'(1) << bit_q);
      end else if (scan.hit) begin
        wdata_q <= rdata | (WORD_BITS'(1) << scan.pos);
        found_q <= IDW'({waddr, scan.pos});
        grant_q <= 1'b1;
      end else begin
        found_q <= '0;
        grant_q <= 1'b0;
        step <= step + 1'b1;
        waddr <= (waddr == LAST_WORD) ? '0 : waddr + 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (state == S_RESULT && slot_free) begin
      id_out <= ID_IO_W'(found_q);
      granted <= grant_q;
    end
  end

  // a grant never hands out identifier zero, a failure always reports zero
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (granted ? (id_out != '0) : (id_out == '0)))
    else $error("result word inconsistent");

  // the hint stays inside the identifier space, never zero
  assert property (@(posedge clk) disable iff (rst)
    (hint != '0) && (32'(hint) < ID_COUNT))
    else $error("search hint out of range");

  // the scan never runs past the wrap word
  assert property (@(posedge clk) disable iff (rst)
    (state == S_EVAL) |-> (step <= LAST_STEP))
    else $error("scan step overrun");

  // a finished allocate never overwrites a pending result word
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready && state == S_RESULT) |=> (state == S_RESULT))
    else $error("pending result overwritten");

endmodule

`default_nettype wire
